FILE: hw/rtl/ror_pkg.sv
// Shared types and constants for the rank-order remap unit.
`timescale 1ns / 1ps
`default_nettype none

package ror_pkg;

    // Field widths of the stream words
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int RANK_W  = 10;
    localparam int SEQ_W   = 11;
    localparam int OP_W    = 2;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_WR_REF    = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;

    // Reset value of the length register
    localparam logic [SEQ_W-1:0] SEQ_LENGTH_RST = 11'd1024;

    // Engine status toward the stream side
    typedef struct packed {
        logic busy;
        logic done;
    } ror_status_t;

    // Finished query result
    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [VALUE_W-1:0] remapped_value;
    } ror_result_t;

endpackage : ror_pkg

`default_nettype wire

FILE: hw/rtl/ror_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ror_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : ror_ram

`default_nettype wire

FILE: hw/rtl/ror_rank_engine.sv
// Query sequencer: fetches the key, scans the sample RAM for its rank,
// then looks up the reference RAM at that rank.
`timescale 1ns / 1ps
`default_nettype none

module ror_rank_engine
    import ror_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // query start, one cycle
    input  wire logic                       start,
    input  wire logic [$clog2(DEPTH)-1:0]   start_pos,
    input  wire logic [$clog2(DEPTH+1)-1:0] start_len,
    // result taken by the output stage
    input  wire logic                       take,
    // sample RAM read port
    output logic                            samp_re,
    output logic      [$clog2(DEPTH)-1:0]   samp_raddr,
    input  wire logic [VALUE_W-1:0]         samp_rdata,
    // reference RAM read port
    output logic                            ref_re,
    output logic      [$clog2(DEPTH)-1:0]   ref_raddr,
    input  wire logic [VALUE_W-1:0]         ref_rdata,
    // status and result
    output ror_status_t                     status,
    output ror_result_t                     result
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_REF  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic [LW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [AW-1:0]      rank_reg, rank_next;
    ror_result_t        res_reg, res_next;
    logic               below_key;

    // Registered sample read versus the signed key, stable tie rule
    assign below_key = ($signed(samp_rdata) < $signed(key_reg)) ||
                       ((samp_rdata == key_reg) && (rd_idx_reg < pos_reg));

    // Sequencer next state and RAM read addressing
    always_comb begin
        state_next  = state_reg;
        rd_vld_next = rd_vld_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        rank_next   = rank_reg;
        res_next    = res_reg;
        samp_re     = 1'b0;
        samp_raddr  = '0;
        ref_re      = 1'b0;
        ref_raddr   = rank_reg;
        case (state_reg)
            ST_IDLE: begin
                samp_re    = start;
                samp_raddr = start_pos;
                if (start) begin
                    pos_next   = start_pos;
                    len_next   = start_len;
                    state_next = ST_KEY;
                end
            end
            ST_KEY: begin
                // key arrives; first scan read goes out
                key_next    = samp_rdata;
                samp_re     = 1'b1;
                samp_raddr  = '0;
                cnt_next    = LW'(1);
                rd_vld_next = 1'b1;
                rd_idx_next = '0;
                rank_next   = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                if (rd_vld_reg && below_key) begin
                    rank_next = rank_reg + AW'(1);
                end
                if (cnt_reg < len_reg) begin
                    samp_re     = 1'b1;
                    samp_raddr  = cnt_reg[AW-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[AW-1:0];
                    cnt_next    = cnt_reg + LW'(1);
                end else begin
                    rd_vld_next = 1'b0;
                end
                // scan drained: rank is final
                if (!rd_vld_reg) begin
                    ref_re     = 1'b1;
                    state_next = ST_REF;
                end
            end
            ST_REF: begin
                res_next.remapped_value = ref_rdata;
                res_next.rank           = RANK_W'(rank_reg);
                state_next              = ST_DONE;
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        len_reg    <= len_next;
        key_reg    <= key_next;
        cnt_reg    <= cnt_next;
        rd_idx_reg <= rd_idx_next;
        rank_reg   <= rank_next;
        res_reg    <= res_next;
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign result      = res_reg;

    // Rank stays inside the active length
    a_rank_in_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REF) |-> (32'(rank_reg) < 32'(len_reg)))
        else $error("rank reached the active length");

    // A query only starts from idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == ST_IDLE))
        else $error("query started while busy");

    // Drained scan hands over to the reference lookup
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !rd_vld_reg) |=> (state_reg == ST_REF))
        else $error("scan end not followed by reference lookup");

    // Result is held until taken
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !take) |=> (state_reg == ST_DONE && $stable(res_reg)))
        else $error("result lost before it was taken");

endmodule : ror_rank_engine

`default_nettype wire

FILE: hw/rtl/rank_order_remap_unit.sv
// Top level of the rank-order remap unit: stream ports, tables, output register.
// Writes: a write word takes effect in the accept cycle and gives no result. A read query
// shows its result on m_tvalid after the rank scan over the active length and the reference
// lookup. Throughput: one write per cycle while no query runs; a new query waits until the
// last result is taken, as the scan walks the single sample RAM read port one entry a cycle.
// Reset: control state clears and seq_length returns to 1024; table contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module rank_order_remap_unit
    import ror_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // length register
    input  wire logic             cfg_wen,
    input  wire logic [SEQ_W-1:0] cfg_wdata,
    // input words
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [47:0]      s_tdata,  // [9:0] position, [41:10] value, [47:42] zero
    input  wire logic [OP_W-1:0]  s_tuser,  // [1:0] op
    // result words
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [47:0]      m_tdata   // [31:0] remapped_value, [41:32] rank, [47:42] zero
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [SEQ_W-1:0]   seq_length_reg;
    logic [LW-1:0]      eff_len;
    logic               s_accept;
    logic [OP_W-1:0]    in_op;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_value;
    logic               pos_in_depth;
    logic               pos_in_len;
    logic               ref_we, samp_we, q_start;
    logic               samp_re, ref_re;
    logic [AW-1:0]      samp_raddr, ref_raddr;
    logic [VALUE_W-1:0] samp_rdata, ref_rdata;
    ror_status_t        eng_status;
    ror_result_t        eng_result;
    logic               take;
    logic               m_valid_reg;
    ror_result_t        m_data_reg;

    // Length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg <= SEQ_LENGTH_RST;
        end else if (cfg_wen) begin
            seq_length_reg <= cfg_wdata;
        end
    end

    // Active length, clamped to 1..DEPTH
    always_comb begin
        if (seq_length_reg == '0) begin
            eff_len = LW'(1);
        end else if (32'(seq_length_reg) > DEPTH) begin
            eff_len = LW'(DEPTH);
        end else begin
            eff_len = LW'(seq_length_reg);
        end
    end

    // Input word decode
    assign in_op        = s_tuser;
    assign in_pos       = s_tdata[POS_W-1:0];
    assign in_value     = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign s_tready     = !eng_status.busy;
    assign s_accept     = s_tvalid && s_tready;
    assign pos_in_depth = (32'(in_pos) < DEPTH);
    assign pos_in_len   = (32'(in_pos) < 32'(eff_len));

    assign ref_we  = s_accept && (in_op == OP_WR_REF) && pos_in_depth;
    assign samp_we = s_accept && (in_op == OP_WR_SAMPLE) && pos_in_depth;
    assign q_start = s_accept && (in_op == OP_READ) && pos_in_len;

    // Reference table
    ror_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (AW'(in_pos)),
        .wdata (in_value),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    // Sample table
    ror_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_samp_ram (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (AW'(in_pos)),
        .wdata (in_value),
        .re    (samp_re),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    // Rank scan and lookup
    ror_rank_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (q_start),
        .start_pos  (AW'(in_pos)),
        .start_len  (eff_len),
        .take       (take),
        .samp_re    (samp_re),
        .samp_raddr (samp_raddr),
        .samp_rdata (samp_rdata),
        .ref_re     (ref_re),
        .ref_raddr  (ref_raddr),
        .ref_rdata  (ref_rdata),
        .status     (eng_status),
        .result     (eng_result)
    );

    // Output register
    assign take = eng_status.done && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= eng_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.rank, m_data_reg.remapped_value};

    // A taken result is on the output next cycle
    a_take_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_tvalid)
        else $error("taken result not presented");

    // An accepted in-range query occupies the engine
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_start |=> (eng_status.busy && !s_tready))
        else $error("query accepted but engine not busy");

    // No table write while a query is running
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.busy |-> (!ref_we && !samp_we))
        else $error("table written during a query");

endmodule : rank_order_remap_unit

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the rank-order remap unit: table loads, rank queries, lengths.
`timescale 1ns / 1ps

module testbench;
    import ror_pkg::*;

    localparam int TBL_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 500;
    // op code that the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Predicts remap results from private copies of both tables and the length register
    class remap_scoreboard;
        logic [VALUE_W-1:0] ref_tbl [TBL_DEPTH];
        logic [VALUE_W-1:0] smp_tbl [TBL_DEPTH];
        logic [SEQ_W-1:0]   seq_len;
        ror_result_t        expected_q [$];
        int                 errors;

        function new();
            seq_len = SEQ_LENGTH_RST;
            errors  = 0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                ref_tbl[i] = '0;
                smp_tbl[i] = '0;
            end
        endfunction

        function void set_length(logic [SEQ_W-1:0] v);
            seq_len = v;
        endfunction

        // zero acts as one, anything above the depth as the depth
        function int active_length();
            if (seq_len == 0) return 1;
            if (seq_len > TBL_DEPTH) return TBL_DEPTH;
            return int'(seq_len);
        endfunction

        function bit empty();
            return expected_q.size() == 0;
        endfunction

        // Apply one accepted input word; queries in range queue an expected result
        function void note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] val);
            int len;
            int cnt;
            logic signed [VALUE_W-1:0] key;
            ror_result_t res;
            len = active_length();
            case (op)
                OP_WR_REF: begin
                    ref_tbl[pos] = val;
                end
                OP_WR_SAMPLE: begin
                    smp_tbl[pos] = val;
                end
                OP_READ: begin
                    if (int'(pos) < len) begin
                        key = smp_tbl[pos];
                        cnt = 0;
                        // smaller values, plus equal values at lower positions
                        for (int j = 0; j < len; j++) begin
                            if ($signed(smp_tbl[j]) < key ||
                                (smp_tbl[j] == key && j < int'(pos))) cnt++;
                        end
                        res.rank           = cnt[RANK_W-1:0];
                        res.remapped_value = ref_tbl[cnt];
                        expected_q = {expected_q, res};
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one result word against the oldest expectation
        function void check_result(logic [47:0] word);
            ror_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with none expected: expected none, actual %h",
                         $time, word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (word[31:0] !== want.remapped_value) begin
                $display("%0t: remapped_value mismatch: expected %h, actual %h",
                         $time, want.remapped_value, word[31:0]);
                errors++;
            end
            if (word[41:32] !== want.rank) begin
                $display("%0t: rank mismatch: expected %0d, actual %0d",
                         $time, want.rank, word[41:32]);
                errors++;
            end
            if (word[47:42] !== 6'd0) begin
                $display("%0t: padding mismatch: expected %h, actual %h",
                         $time, 6'd0, word[47:42]);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wen;
    logic [SEQ_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;   // [9:0] position, [41:10] value, [47:42] zero
    logic [OP_W-1:0]    s_tuser;   // [1:0] op
    logic               m_tvalid;
    logic               m_tready;
    logic [47:0]        m_tdata;   // [31:0] remapped_value, [41:32] rank, [47:42] zero

    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 random_count;
    logic [VALUE_W-1:0] tie_pool [4];
    remap_scoreboard    sb;

    rank_order_remap_unit #(
        .DEPTH(TBL_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

    // Result side: check every accepted word, then pick the next ready level
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Push one word on the input stream after a random idle gap
    task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [VALUE_W-1:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, val, pos};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_word(op, pos, val);
    endtask

    // Stop sending until every queued result has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (!sb.empty()) @(posedge aclk);
    endtask

    // Length register write, only with the block idle
    task automatic write_length(input logic [SEQ_W-1:0] v);
        hold_until_drained();
        // a query out of range gives no word and starts no scan
        repeat (sb.active_length() + 10) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.set_length(v);
    endtask

    // Ascending reference entries 0..n-1, spread so the sum cannot wrap
    task automatic write_sorted_refs(input int n);
        logic [VALUE_W-1:0] step_max;
        logic [VALUE_W-1:0] acc;
        step_max = 32'hFFFF_FFFF / n;
        acc = $urandom_range(0, step_max);
        for (int i = 0; i < n; i++) begin
            send_word(OP_WR_REF, i[POS_W-1:0], acc ^ 32'h8000_0000);
            acc += $urandom_range(0, step_max);
        end
    endtask

    // Sample value with extremes and frequent ties
    function automatic logic [VALUE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return tie_pool[$urandom_range(0, 3)];
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial begin
        int len;
        int n_items;
        int r;
        int loaded_len;
        logic [POS_W-1:0] p;

        sb = new();
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WR_REF;
        send_idle_pct = 24;
        recv_idle_pct = 75;
        random_count  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: four entries, extreme values, a tie, out-of-range query, unused op
        write_length(11'd4);
        send_word(OP_WR_REF, 10'd0, 32'h8000_0000);
        send_word(OP_WR_REF, 10'd1, 32'hFFFF_FFFF);
        send_word(OP_WR_REF, 10'd2, 32'h0000_0000);
        send_word(OP_WR_REF, 10'd3, 32'h7FFF_FFFF);
        send_word(OP_WR_SAMPLE, 10'd0, 32'h7FFF_FFFF);
        send_word(OP_WR_SAMPLE, 10'd1, 32'h8000_0000);
        send_word(OP_WR_SAMPLE, 10'd2, 32'h0001_0000);
        send_word(OP_WR_SAMPLE, 10'd3, 32'h0001_0000);
        for (int i = 0; i < 4; i++) send_word(OP_READ, i[POS_W-1:0], 32'h0);
        send_word(OP_READ, 10'd4, 32'h0);
        send_word(OP_READ, 10'd1023, 32'hFFFF_FFFF);
        send_word(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF);
        send_word(OP_READ, 10'd3, 32'hFFFF_FFFF);
        // tie between the two maxima: lower position ranks first
        send_word(OP_WR_SAMPLE, 10'd2, 32'h7FFF_FFFF);
        send_word(OP_READ, 10'd0, 32'h0);
        send_word(OP_READ, 10'd2, 32'h0);
        loaded_len = 4;

        // Random phases at short lengths
        while (random_count < RANDOM_ITEMS) begin
            if (random_count < RANDOM_ITEMS / 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 75;
            end else if (random_count < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 1;
                default: len = $urandom_range(2, 24);
            endcase
            write_length(len[SEQ_W-1:0]);
            len = sb.active_length();
            for (int k = 0; k < 4; k++) tie_pool[k] = $urandom;

            // usually a fresh load, always when the length reaches past loaded entries
            if (len > loaded_len || $urandom_range(0, 9) < 7) begin
                write_sorted_refs(len);
                for (int i = 0; i < len; i++) send_word(OP_WR_SAMPLE, i[POS_W-1:0], pick_sample());
                random_count += 2 * len;
                if (len > loaded_len) loaded_len = len;
            end

            n_items = $urandom_range(20, 50);
            repeat (n_items) begin
                r = $urandom_range(0, 99);
                p = POS_W'($urandom_range(0, len - 1));
                if (r < 45) begin
                    send_word(OP_READ, p, $urandom);
                    random_count++;
                end else if (r < 55) begin
                    p = POS_W'($urandom);
                    send_word(OP_READ, p, $urandom);
                    if (p < len) random_count++;
                end else if (r < 72) begin
                    send_word(OP_WR_SAMPLE, p, pick_sample());
                    random_count++;
                end else if (r < 82) begin
                    send_word(OP_WR_REF, p, $urandom);
                    random_count++;
                end else if (r < 90) begin
                    send_word($urandom_range(0, 1) ? OP_WR_REF : OP_WR_SAMPLE,
                              POS_W'($urandom), $urandom);
                    random_count++;
                end else if (r < 95) begin
                    send_word(OP_UNUSED, POS_W'($urandom), $urandom);
                end else begin
                    hold_until_drained();
                end
            end
        end

        // Drain and let any scan still running finish
        hold_until_drained();
        repeat (sb.active_length() + 10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
